/* src/tcw_pkg.sv */
// shared types and constants of the text console writer
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [7:0] NEWLINE_CODE   = 8'd10;
  localparam logic [7:0] SPACE_CODE     = 8'd32;
  localparam logic [7:0] DEF_ATTR_RESET = 8'h0f;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic       use_position;
    logic [4:0] row_index;
    logic [6:0] column_index;
  } in_req_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attribute;
    logic       scrolled;
  } out_res_t;

  typedef enum logic [1:0] {
    SWP_ZERO,
    SWP_COPY,
    SWP_FILL
  } sweep_mode_t;

  typedef struct packed {
    logic        load;
    logic        exec;
    logic        sweep;
    sweep_mode_t mode;
    logic        emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       scroll_need;
    logic       sweep_last;
  } dp_sts_t;

endpackage
`default_nettype wire

/* src/text_console_writer.sv */
// text console writer top level: register port, controller and datapath
// results: a put, newline or unused kind is answered from the execute state, a read after
//   the readout state, a put that scrolls or a clear after a sweep of the whole screen
//   (one write port, one cell per cycle); a new request is taken only while idle
// reset: cursor homes, default attribute is 0x0f, then a pass zeroes the screen with busy
//   high; the result strobe cannot be stalled by the receiver
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire tcw_pkg::in_req_t  in_req,
  output      logic              out_valid,
  output      tcw_pkg::out_res_t out_res,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);
  import tcw_pkg::*;

  localparam logic REG_DEF_ATTR = 1'b0;

  logic [7:0] def_attr_r;
  ctl_cmd_t   cmd;
  dp_sts_t    sts;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DEF_ATTR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_attr_r <= DEF_ATTR_RESET;
    end else if (cfg_wr) begin
      def_attr_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_DEF_ATTR) ? {24'd0, def_attr_r} : 32'd0;

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tcw_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_req),
    .def_attr  (def_attr_r),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

`ifndef ASSERT_OFF
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy next cycle");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((int'(out_res.cursor_row) < ROWS) && (int'(out_res.cursor_col) < COLS)))
    else $error("reported cursor outside the screen");

  a_reset_pass: assert property (@(posedge clk)
    !rst_n |=> (busy && !out_valid))
    else $error("screen clearing pass not running after reset");
`endif

endmodule
`default_nettype wire

/* src/tcw_ctrl.sv */
// control state machine of the text console writer
`timescale 1ns / 1ps
`default_nettype none
module tcw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire tcw_pkg::dp_sts_t   sts,
  output      tcw_pkg::ctl_cmd_t  cmd,
  output      logic               busy
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_INIT_END,
    ST_IDLE,
    ST_EXEC,
    ST_RDOUT,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  state_t      state_r, state_nxt;
  sweep_mode_t mode_r, mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      mode_r  <= SWP_ZERO;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cmd       = '0;
    cmd.mode  = mode_r;
    case (state_r)
      ST_INIT: begin
        // power-up pass zeroes the screen
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_nxt = ST_INIT_END;
      end
      ST_INIT_END: begin
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.kind)
          KIND_PUT: begin
            if (sts.scroll_need) begin
              mode_nxt  = SWP_COPY;
              state_nxt = ST_SWEEP;
            end else begin
              cmd.emit  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          KIND_READ: begin
            state_nxt = ST_RDOUT;
          end
          KIND_CLEAR: begin
            mode_nxt  = SWP_FILL;
            state_nxt = ST_SWEEP;
          end
          default: begin
            cmd.emit  = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_RDOUT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // last sweep write lands in this cycle
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

/* src/tcw_dp.sv */
// datapath of the text console writer: cursor, screen memory, sweep and result register
`timescale 1ns / 1ps
`default_nettype none
module tcw_dp #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tcw_pkg::ctl_cmd_t  cmd,
  output      tcw_pkg::dp_sts_t   sts,
  input  wire tcw_pkg::in_req_t   in_req,
  input  wire logic [7:0]         def_attr,
  output      logic               out_valid,
  output      tcw_pkg::out_res_t  out_res
);
  import tcw_pkg::*;

  localparam int CELLS      = ROWS * COLS;
  localparam int AW         = $clog2(CELLS);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLS);
  localparam int COPY_CELLS = (ROWS - 1) * COLS;

  localparam logic [AW-1:0] COLS_A    = AW'(COLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(COPY_CELLS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);

  logic [15:0]   cells_mem [CELLS];
  logic [15:0]   rdata_r;

  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic          scroll_r, scroll_nxt;
  logic [1:0]    kind_r;
  logic [7:0]    char_r;
  logic [7:0]    attr_r;
  logic [RW-1:0] tgt_row_r;
  logic [CW-1:0] tgt_col_r;

  logic [AW-1:0] idx_r;
  logic          wr_pend_r;
  logic [AW-1:0] wr_addr_r;
  sweep_mode_t   wr_src_r;

  logic          out_valid_r;
  out_res_t      out_res_r, out_res_nxt;

  logic [RW-1:0] ld_row;
  logic [CW-1:0] ld_col;
  logic          is_nl, wrap, at_last_row, scroll_need;
  logic [RW-1:0] row_adv;
  logic [CW-1:0] col_adv;
  logic [AW-1:0] tgt_addr, rd_addr, wr_addr;
  logic          in_copy, wr_en;
  logic [15:0]   wr_data;

  // target cell of a new request: its position saturated into the screen, else the cursor
  always_comb begin
    if (in_req.use_position) begin
      if (int'(in_req.row_index) > ROWS - 1) ld_row = LAST_ROW;
      else ld_row = RW'(in_req.row_index);
      if (int'(in_req.column_index) > COLS - 1) ld_col = LAST_COL;
      else ld_col = CW'(in_req.column_index);
    end else begin
      ld_row = cur_row_r;
      ld_col = cur_col_r;
    end
  end

  // cursor advance of a put
  always_comb begin
    is_nl       = (char_r == NEWLINE_CODE);
    wrap        = is_nl || (tgt_col_r == LAST_COL);
    at_last_row = (tgt_row_r == LAST_ROW);
    scroll_need = wrap && at_last_row;
    col_adv     = wrap ? '0 : tgt_col_r + CW'(1);
    row_adv     = (wrap && !at_last_row) ? tgt_row_r + RW'(1) : tgt_row_r;
  end

  assign tgt_addr = AW'(tgt_row_r) * COLS_A + AW'(tgt_col_r);
  assign in_copy  = (idx_r < COPY_END);
  assign rd_addr  = (cmd.sweep && in_copy) ? idx_r + COLS_A : (cmd.sweep ? idx_r : tgt_addr);

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    scroll_nxt  = scroll_r;
    if (cmd.load) scroll_nxt = 1'b0;
    if (cmd.exec) begin
      case (kind_r)
        KIND_PUT: begin
          cur_row_nxt = row_adv;
          cur_col_nxt = col_adv;
          scroll_nxt  = scroll_need;
        end
        KIND_CLEAR: begin
          cur_row_nxt = '0;
          cur_col_nxt = '0;
        end
        default: begin
          cur_row_nxt = cur_row_r;
          cur_col_nxt = cur_col_r;
        end
      endcase
    end
  end

  // one write port: a pending sweep write, else the put of the current request
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tgt_addr;
    wr_data = {attr_r, char_r};
    if (wr_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = wr_addr_r;
      case (wr_src_r)
        SWP_COPY: wr_data = rdata_r;
        SWP_FILL: wr_data = {def_attr, SPACE_CODE};
        default:  wr_data = '0;
      endcase
    end else if (cmd.exec && (kind_r == KIND_PUT) && !is_nl) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) cells_mem[wr_addr] <= wr_data;
    rdata_r <= cells_mem[rd_addr];
  end

  always_comb begin
    out_res_nxt.cursor_row     = 5'(cur_row_nxt);
    out_res_nxt.cursor_col     = 7'(cur_col_nxt);
    out_res_nxt.cell_char      = (kind_r == KIND_READ) ? rdata_r[7:0] : 8'd0;
    out_res_nxt.cell_attribute = (kind_r == KIND_READ) ? rdata_r[15:8] : 8'd0;
    out_res_nxt.scrolled       = scroll_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      scroll_r    <= 1'b0;
      idx_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      scroll_r    <= scroll_nxt;
      wr_pend_r   <= cmd.sweep;
      out_valid_r <= cmd.emit;
      if (cmd.sweep) idx_r <= (idx_r == LAST_CELL) ? '0 : idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_req.kind;
      char_r    <= in_req.char_code;
      attr_r    <= (in_req.attribute == 8'd0) ? def_attr : in_req.attribute;
      tgt_row_r <= ld_row;
      tgt_col_r <= ld_col;
    end
    if (cmd.sweep) begin
      wr_addr_r <= idx_r;
      // the copy pass zeroes the bottom row once past the moved rows
      if (cmd.mode == SWP_COPY) wr_src_r <= in_copy ? SWP_COPY : SWP_ZERO;
      else wr_src_r <= cmd.mode;
    end
    if (cmd.emit) out_res_r <= out_res_nxt;
  end

  always_comb begin
    sts.kind        = kind_r;
    sts.scroll_need = scroll_need;
    sts.sweep_last  = (idx_r == LAST_CELL);
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

/* tb/text_console_writer_tb.sv */
// self-checking testbench of the text console writer
`timescale 1ns / 1ps
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int CELLS = ROWS * COLS;
  localparam int LIMIT_CYCLES = 12_000_000;
  localparam int PHASE_ITEMS  = 262;
  localparam int MAX_REPORTS  = 10;

  localparam logic [1:0] KIND_UNUSED      = 2'd3;
  localparam logic [2:0] REG_DEFAULT_ATTR = 3'd0;

  typedef struct {
    in_req_t  req;
    bit       pinned;
    out_res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_req_t     in_req = '0;
  logic        out_valid;
  out_res_t    out_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // typed-in expectation that travels with the request
  logic        pin_on = 1'b0;
  out_res_t    pin_res = '0;

  // console mirror
  logic [15:0] screen_mem [0:CELLS-1];
  int unsigned cursor_lin;
  logic [7:0]  model_def_attr;

  out_res_t    awaited_reports [$];
  dir_row_t    dir_rows [$];
  int          mismatch_count = 0;
  longint      cycle_count = 0;

  text_console_writer #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned target_index(in_req_t req);
    int unsigned r;
    int unsigned c;
    if (!req.use_position) return cursor_lin;
    r = (req.row_index > ROWS - 1) ? ROWS - 1 : req.row_index;
    c = (req.column_index > COLS - 1) ? COLS - 1 : req.column_index;
    return r * COLS + c;
  endfunction

  // applies one request to the mirror and returns the status it reports
  function automatic out_res_t console_step(in_req_t req);
    out_res_t    res;
    int unsigned pos;
    logic [7:0]  attr;
    res = '0;
    case (req.kind)
      KIND_PUT: begin
        pos  = target_index(req);
        attr = (req.attribute == 8'd0) ? model_def_attr : req.attribute;
        if (req.char_code == NEWLINE_CODE) begin
          pos = (pos / COLS + 1) * COLS;
        end else begin
          screen_mem[pos] = {attr, req.char_code};
          pos++;
        end
        if (pos >= CELLS) begin
          for (int i = 0; i < CELLS - COLS; i++) screen_mem[i] = screen_mem[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) screen_mem[i] = '0;
          pos -= COLS;
          res.scrolled = 1'b1;
        end
        cursor_lin = pos;
      end
      KIND_READ: begin
        pos = target_index(req);
        res.cell_char      = screen_mem[pos][7:0];
        res.cell_attribute = screen_mem[pos][15:8];
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_mem[i] = {model_def_attr, SPACE_CODE};
        cursor_lin = 0;
      end
      default: ;
    endcase
    res.cursor_row = 5'(cursor_lin / COLS);
    res.cursor_col = 7'(cursor_lin % COLS);
    return res;
  endfunction

  function automatic void note_failure(string what, out_res_t want, out_res_t got);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch (%s): expected row %0d col %0d char %h attr %h scrolled %b",
               what, want.cursor_row, want.cursor_col, want.cell_char,
               want.cell_attribute, want.scrolled);
      $display("                 got row %0d col %0d char %h attr %h scrolled %b",
               got.cursor_row, got.cursor_col, got.cell_char, got.cell_attribute,
               got.scrolled);
    end
    mismatch_count++;
  endfunction

  // mirror update on accepted requests and register writes, result check
  always @(posedge clk) begin
    out_res_t want;
    out_res_t pred;
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end else if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) screen_mem[i] = '0;
      cursor_lin     = 0;
      model_def_attr = DEF_ATTR_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_DEFAULT_ATTR)
        model_def_attr = pwdata[7:0];
      if (start && !busy) begin
        pred = console_step(in_req);
        awaited_reports.push_back(pin_on ? pin_res : pred);
      end
      if (out_valid) begin
        if (awaited_reports.size() == 0) begin
          note_failure("no result pending", '0, out_res);
        end else begin
          want = awaited_reports.pop_front();
          if (out_res.cursor_row !== want.cursor_row ||
              out_res.cursor_col !== want.cursor_col ||
              out_res.cell_char !== want.cell_char ||
              out_res.cell_attribute !== want.cell_attribute ||
              out_res.scrolled !== want.scrolled)
            note_failure("result", want, out_res);
        end
      end
    end
  end

  function automatic dir_row_t mk_row(logic [1:0] kind, logic [7:0] ch, logic [7:0] attr,
                                      logic up, logic [4:0] r, logic [6:0] c, bit pinned,
                                      logic [4:0] er, logic [6:0] ec, logic [7:0] ech,
                                      logic [7:0] eat, logic es);
    dir_row_t row;
    row.req    = '{kind: kind, char_code: ch, attribute: attr, use_position: up,
                   row_index: r, column_index: c};
    row.pinned = pinned;
    row.res    = '{cursor_row: er, cursor_col: ec, cell_char: ech, cell_attribute: eat,
                   scrolled: es};
    return row;
  endfunction

  function automatic in_req_t random_req();
    in_req_t req;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 72) req.kind = KIND_PUT;
    else if (pick < 92) req.kind = KIND_READ;
    else if (pick < 95) req.kind = KIND_CLEAR;
    else req.kind = KIND_UNUSED;
    req.char_code    = ($urandom_range(99) < 15) ? NEWLINE_CODE : 8'($urandom_range(255));
    req.attribute    = ($urandom_range(99) < 20) ? 8'd0 : 8'($urandom_range(255));
    req.use_position = 1'($urandom_range(1));
    // lean toward the bottom right so that scrolls and saturation come often
    req.row_index    = 5'(($urandom_range(99) < 35) ? $urandom_range(20, 31)
                                                    : $urandom_range(0, 31));
    req.column_index = 7'(($urandom_range(99) < 35) ? $urandom_range(72, 127)
                                                    : $urandom_range(0, 127));
    return req;
  endfunction

  task automatic send_req(in_req_t req, bit pinned, out_res_t res, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_req  <= req;
    pin_on  <= pinned;
    pin_res <= res;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    // one edge first so the last accepted request is queued and busy has risen
    @(posedge clk);
    while (awaited_reports.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_default_attr(logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DEFAULT_ATTR;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== value) begin
      if (mismatch_count < MAX_REPORTS)
        $display("mismatch (register read): expected %h got %h", value, prdata[7:0]);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int       idle_pct [4];
    logic [7:0] attr_set [4];
    dir_row_t row;

    idle_pct = '{0, 68, 8, 0};
    attr_set = '{8'h00, 8'hff, 8'($urandom_range(1, 254)), DEF_ATTR_RESET};

    // reset state: zero screen, cursor home, default attribute 0x0f
    dir_rows.push_back(mk_row(KIND_READ,  8'h00, 8'h00, 1'b0, 5'd0,  7'd0,   1, 0,  0,  0, 0, 0));
    dir_rows.push_back(mk_row(KIND_READ,  8'h00, 8'h00, 1'b1, 5'd31, 7'd127, 1, 0,  0,  0, 0, 0));
    dir_rows.push_back(mk_row(KIND_PUT,   8'h41, 8'h00, 1'b0, 5'd0,  7'd0,   1, 0,  1,  0, 0, 0));
    dir_rows.push_back(mk_row(KIND_READ,  8'h00, 8'h00, 1'b1, 5'd0,  7'd0,   1, 0,  1,
                              8'h41, 8'h0f, 0));
    dir_rows.push_back(mk_row(KIND_PUT,   8'hff, 8'hff, 1'b1, 5'd0,  7'd79,  1, 1,  0,  0, 0, 0));
    dir_rows.push_back(mk_row(KIND_PUT,   NEWLINE_CODE, 8'h00, 1'b0, 5'd0, 7'd0, 1, 2, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(KIND_PUT,   8'h00, 8'h80, 1'b1, 5'd12, 7'd40,  0, 0,  0,  0, 0, 0));
    dir_rows.push_back(mk_row(KIND_UNUSED, 8'hff, 8'hff, 1'b1, 5'd31, 7'd127, 1, 12, 41, 0, 0, 0));
    // last cell written: scroll, cursor to start of bottom row
    dir_rows.push_back(mk_row(KIND_PUT,   8'h55, 8'h01, 1'b1, 5'd24, 7'd79,  1, 24, 0,  0, 0, 1));
    dir_rows.push_back(mk_row(KIND_READ,  8'h00, 8'h00, 1'b1, 5'd23, 7'd79,  1, 24, 0,
                              8'h55, 8'h01, 0));
    dir_rows.push_back(mk_row(KIND_READ,  8'h00, 8'h00, 1'b1, 5'd24, 7'd79,  1, 24, 0, 0, 0, 0));
    // newline on the bottom row, plain and saturated
    dir_rows.push_back(mk_row(KIND_PUT,   NEWLINE_CODE, 8'h07, 1'b1, 5'd24, 7'd5, 1, 24, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(KIND_PUT,   NEWLINE_CODE, 8'h00, 1'b1, 5'd31, 7'd127, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(KIND_READ,  8'h00, 8'h00, 1'b1, 5'd21, 7'd79,  0, 0,  0,  0, 0, 0));
    dir_rows.push_back(mk_row(KIND_CLEAR, 8'h00, 8'h00, 1'b0, 5'd0,  7'd0,   1, 0,  0,  0, 0, 0));
    dir_rows.push_back(mk_row(KIND_READ,  8'h00, 8'h00, 1'b1, 5'd24, 7'd79,  1, 0,  0,
                              SPACE_CODE, 8'h0f, 0));
    dir_rows.push_back(mk_row(KIND_PUT,   8'h7f, 8'h00, 1'b0, 5'd0,  7'd0,   0, 0,  0,  0, 0, 0));
    dir_rows.push_back(mk_row(KIND_PUT,   8'h80, 8'h0e, 1'b1, 5'd3,  7'd100, 0, 0,  0,  0, 0, 0));
    dir_rows.push_back(mk_row(KIND_READ,  8'h00, 8'h00, 1'b1, 5'd3,  7'd127, 0, 0,  0,  0, 0, 0));
    dir_rows.push_back(mk_row(KIND_READ,  8'h00, 8'h00, 1'b0, 5'd16, 7'd64,  0, 0,  0,  0, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      send_req(row.req, row.pinned, row.res, 0);
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_default_attr(attr_set[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_drained();
        send_req(random_req(), 1'b0, '0, idle_pct[ph]);
      end
    end

    start <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (CELLS + 8) @(posedge clk);

    if (mismatch_count == 0 && awaited_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
